@@ rtl/fca_pkg.sv @@
// Package: types, codes and constants shared by the link table allocator.
package fca_pkg;

  localparam int unsigned Entries = 128;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned LinkW   = 8;
  localparam logic [LinkW-1:0] FreeMark = 8'hFF;

  typedef enum logic [2:0] {
    ACT_NEXT   = 3'd0,
    ACT_NTH    = 3'd1,
    ACT_LENGTH = 3'd2,
    ACT_LOOP   = 3'd3,
    ACT_NEW    = 3'd4,
    ACT_EXTEND = 3'd5,
    ACT_FREE   = 3'd6,
    ACT_END    = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_FREE    = 3'd2,
    ST_END     = 3'd3,
    ST_NOSPACE = 3'd4,
    ST_LOOP    = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_WALK_RD,
    S_WALK_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_t;

  // Memory access request from the sequencer to the table.
  typedef struct packed {
    logic             rd_en;
    logic [IdxW-1:0]  rd_addr;
    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    logic [LinkW-1:0] wr_data;
  } mem_req_t;

endpackage

@@ rtl/fca_if.sv @@
// Valid/ready channel interfaces for items and results.
interface fca_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [6:0] block;
  logic [6:0] step_count;
  modport source (output valid, action, block, step_count, input ready);
  modport sink   (input valid, action, block, step_count, output ready);
endinterface

interface fca_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] block_out;
  logic [6:0] chain_length;
  modport source (output valid, status, block_out, chain_length, input ready);
  modport sink   (input valid, status, block_out, chain_length, output ready);
endinterface

@@ rtl/fca_table.sv @@
// Link table memory: one write port, one registered read port.
module fca_table (
  input  logic                    clk,
  input  fca_pkg::mem_req_t       req,
  output logic [fca_pkg::LinkW-1:0] rd_data
);

  logic [fca_pkg::LinkW-1:0] mem [fca_pkg::Entries];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ rtl/fca_seq.sv @@
// Sequencer: walks chains, scans for free entries and edits the link table.
module fca_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  fca_in_if.sink                     in_ch,
  fca_out_if.source                  out_ch,
  output fca_pkg::mem_req_t          req,
  input  logic [fca_pkg::LinkW-1:0]  rd_data
);

  localparam int unsigned IdxW = fca_pkg::IdxW;
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] EntCnt = CntW'(fca_pkg::Entries);

  fca_pkg::state_t  state_r, state_nxt;
  fca_pkg::action_t act_r, act_nxt;
  logic [IdxW-1:0]  cur_r, cur_nxt;
  logic [IdxW-1:0]  start_r, start_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [CntW-1:0]  lim_r, lim_nxt;
  logic [IdxW-1:0]  last_r, last_nxt;
  logic [CntW-1:0]  init_r, init_nxt;
  fca_pkg::status_t st_r, st_nxt;
  logic [6:0]       bout_r, bout_nxt;
  logic [6:0]       len_r, len_nxt;
  logic             oval_r, oval_nxt;

  logic             blk_ok;
  logic             link_ok;
  logic [IdxW-1:0]  link_idx;

  assign blk_ok   = {1'b0, in_ch.block} < 8'(fca_pkg::Entries);
  assign link_ok  = rd_data < fca_pkg::LinkW'(fca_pkg::Entries);
  assign link_idx = rd_data[IdxW-1:0];

  assign in_ch.ready         = (state_r == fca_pkg::S_IDLE) && !oval_r;
  assign out_ch.valid        = oval_r;
  assign out_ch.status       = st_r;
  assign out_ch.block_out    = bout_r;
  assign out_ch.chain_length = len_r;

  // State and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fca_pkg::S_INIT;
      init_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      oval_r  <= oval_nxt;
    end
    act_r   <= act_nxt;
    cur_r   <= cur_nxt;
    start_r <= start_nxt;
    cnt_r   <= cnt_nxt;
    lim_r   <= lim_nxt;
    last_r  <= last_nxt;
    st_r    <= st_nxt;
    bout_r  <= bout_nxt;
    len_r   <= len_nxt;
  end

  // Next state, memory requests and results
  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    cur_nxt   = cur_r;
    start_nxt = start_r;
    cnt_nxt   = cnt_r;
    lim_nxt   = lim_r;
    last_nxt  = last_r;
    init_nxt  = init_r;
    st_nxt    = st_r;
    bout_nxt  = bout_r;
    len_nxt   = len_r;
    oval_nxt  = oval_r;
    req       = '0;
    if (oval_r && out_ch.ready) begin
      oval_nxt = 1'b0;
    end
    case (state_r)
      fca_pkg::S_INIT: begin
        // Clear the table: entry 0 links to 1, entry 1 ends, rest free
        req.wr_en   = 1'b1;
        req.wr_addr = init_r[IdxW-1:0];
        if (init_r == '0) begin
          req.wr_data = 8'd1;
        end else if (init_r == CntW'(1)) begin
          req.wr_data = 8'd0;
        end else begin
          req.wr_data = fca_pkg::FreeMark;
        end
        init_nxt = init_r + CntW'(1);
        if (init_r == EntCnt - CntW'(1)) begin
          state_nxt = fca_pkg::S_IDLE;
        end
      end
      fca_pkg::S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          act_nxt   = fca_pkg::action_t'(in_ch.action);
          cur_nxt   = in_ch.block[IdxW-1:0];
          start_nxt = in_ch.block[IdxW-1:0];
          cnt_nxt   = '0;
          st_nxt    = fca_pkg::ST_OK;
          bout_nxt  = '0;
          len_nxt   = '0;
          lim_nxt   = EntCnt;
          case (fca_pkg::action_t'(in_ch.action))
            fca_pkg::ACT_NEXT, fca_pkg::ACT_LENGTH: begin
              if (!blk_ok) begin
                st_nxt = fca_pkg::ST_RANGE; state_nxt = fca_pkg::S_DONE;
              end else begin
                if (in_ch.action == fca_pkg::ACT_NEXT) lim_nxt = CntW'(1);
                state_nxt = fca_pkg::S_WALK_RD;
              end
            end
            fca_pkg::ACT_NTH: begin
              lim_nxt = CntW'(in_ch.step_count);
              if (in_ch.step_count == '0) begin
                bout_nxt = in_ch.block; state_nxt = fca_pkg::S_DONE;
              end else if (!blk_ok) begin
                st_nxt = fca_pkg::ST_RANGE; state_nxt = fca_pkg::S_DONE;
              end else begin
                state_nxt = fca_pkg::S_WALK_RD;
              end
            end
            fca_pkg::ACT_LOOP, fca_pkg::ACT_EXTEND, fca_pkg::ACT_FREE: begin
              if (!blk_ok || in_ch.block == '0) begin
                st_nxt = fca_pkg::ST_RANGE; state_nxt = fca_pkg::S_DONE;
              end else begin
                state_nxt = fca_pkg::S_WALK_RD;
              end
            end
            fca_pkg::ACT_NEW: begin
              // Scan from the lowest entry
              cur_nxt   = '0;
              state_nxt = fca_pkg::S_SCAN_RD;
            end
            default: begin
              if (!blk_ok) begin
                st_nxt = fca_pkg::ST_RANGE;
              end else begin
                req.wr_en   = 1'b1;
                req.wr_addr = in_ch.block[IdxW-1:0];
                req.wr_data = '0;
              end
              state_nxt = fca_pkg::S_DONE;
            end
          endcase
        end
      end
      fca_pkg::S_WALK_RD: begin
        if (cnt_r == lim_r) begin
          // Limit reached without an end link
          case (act_r)
            fca_pkg::ACT_NTH: bout_nxt = 7'(cur_r);
            fca_pkg::ACT_NEXT: ;
            default: st_nxt = fca_pkg::ST_LOOP;
          endcase
          state_nxt = fca_pkg::S_DONE;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = cur_r;
          state_nxt   = fca_pkg::S_WALK_CHK;
        end
      end
      fca_pkg::S_WALK_CHK: begin
        state_nxt = fca_pkg::S_DONE;
        if (rd_data == fca_pkg::FreeMark) begin
          st_nxt = fca_pkg::ST_FREE;
        end else if (rd_data == '0) begin
          // End of chain
          case (act_r)
            fca_pkg::ACT_NTH: st_nxt = fca_pkg::ST_END;
            fca_pkg::ACT_LENGTH: len_nxt = (cnt_r > CntW'(127)) ? 7'd127 : 7'(cnt_r);
            fca_pkg::ACT_EXTEND: begin
              last_nxt = cur_r; cur_nxt = '0; state_nxt = fca_pkg::S_SCAN_RD;
            end
            fca_pkg::ACT_FREE: begin
              cur_nxt = start_r; state_nxt = fca_pkg::S_FREE_RD;
            end
            default: ;
          endcase
        end else if (!link_ok) begin
          st_nxt = fca_pkg::ST_RANGE;
        end else begin
          cur_nxt = link_idx;
          cnt_nxt = cnt_r + CntW'(1);
          if (act_r == fca_pkg::ACT_NEXT) begin
            bout_nxt = 7'(link_idx);
          end else begin
            state_nxt = fca_pkg::S_WALK_RD;
          end
        end
      end
      fca_pkg::S_SCAN_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = cur_r;
        state_nxt   = fca_pkg::S_SCAN_CHK;
      end
      fca_pkg::S_SCAN_CHK: begin
        if (rd_data == fca_pkg::FreeMark) begin
          req.wr_en   = 1'b1;
          req.wr_addr = cur_r;
          req.wr_data = '0;
          bout_nxt    = 7'(cur_r);
          state_nxt   = fca_pkg::S_DONE;
          if (act_r == fca_pkg::ACT_EXTEND) begin
            state_nxt = fca_pkg::S_FREE_CHK;
          end
        end else if (cur_r == IdxW'(fca_pkg::Entries - 1)) begin
          st_nxt    = fca_pkg::ST_NOSPACE;
          state_nxt = fca_pkg::S_DONE;
        end else begin
          cur_nxt   = cur_r + IdxW'(1);
          state_nxt = fca_pkg::S_SCAN_RD;
        end
      end
      fca_pkg::S_FREE_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = cur_r;
        state_nxt   = fca_pkg::S_FREE_CHK;
      end
      fca_pkg::S_FREE_CHK: begin
        if (act_r == fca_pkg::ACT_EXTEND) begin
          // Link the old chain end to the new entry
          req.wr_en   = 1'b1;
          req.wr_addr = last_r;
          req.wr_data = fca_pkg::LinkW'(bout_r);
          state_nxt   = fca_pkg::S_DONE;
        end else begin
          req.wr_en   = 1'b1;
          req.wr_addr = cur_r;
          req.wr_data = fca_pkg::FreeMark;
          if (rd_data == '0 || !link_ok) begin
            state_nxt = fca_pkg::S_DONE;
          end else begin
            cur_nxt   = link_idx;
            state_nxt = fca_pkg::S_FREE_RD;
          end
        end
      end
      fca_pkg::S_DONE: begin
        if (!oval_r) begin
          oval_nxt  = 1'b1;
          state_nxt = fca_pkg::S_IDLE;
        end
      end
      default: state_nxt = fca_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/fat_chain_allocator.sv @@
// Top level of the link table chain allocator.
//   channel | dir | payload
//   in_     | in  | action, block, step_count
//   out_    | out | status, block_out, chain_length
// One item at a time. Each link followed or entry scanned takes a read on the
// table's single read port; extend walks the chain then scans for a free entry;
// free chain walks the chain to check it, then reads and frees each link.
// After reset every table entry is initialised before any item is taken.
// A result holds in the output register until taken; no item is taken meanwhile.
module fat_chain_allocator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  input  logic [6:0] in_block,
  input  logic [6:0] in_step_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [6:0] out_block_out,
  output logic [6:0] out_chain_length
);

  fca_in_if  in_ch ();
  fca_out_if out_ch ();
  fca_pkg::mem_req_t         req;
  logic [fca_pkg::LinkW-1:0] rd_data;

  assign in_ch.valid      = in_valid;
  assign in_ch.action     = in_action;
  assign in_ch.block      = in_block;
  assign in_ch.step_count = in_step_count;
  assign in_ready         = in_ch.ready;
  assign out_valid        = out_ch.valid;
  assign out_ch.ready     = out_ready;
  assign out_status       = out_ch.status;
  assign out_block_out    = out_ch.block_out;
  assign out_chain_length = out_ch.chain_length;

  fca_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .req     (req),
    .rd_data (rd_data)
  );

  fca_table u_table (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

@@ bench/fat_chain_allocator_tb.sv @@
// Testbench for the link table chain allocator: self-predicting stimulus and checks.
module fat_chain_allocator_tb;
  import fca_pkg::*;

  typedef struct packed {
    action_t    act;
    logic [6:0] blk;
    logic [6:0] steps;
  } chain_cmd_t;

  typedef struct packed {
    status_t    st;
    logic [6:0] blk;
    logic [6:0] len;
  } chain_reply_t;

  logic clk;
  logic rst_n;
  fca_in_if  in_ch ();
  fca_out_if out_ch ();

  fat_chain_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_action        (in_ch.action),
    .in_block         (in_ch.block),
    .in_step_count    (in_ch.step_count),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_block_out    (out_ch.block_out),
    .out_chain_length (out_ch.chain_length)
  );

  // Predicted link table
  logic [LinkW-1:0] link_tab [Entries];

  chain_cmd_t   pending_cmds [$];
  chain_reply_t expected_replies [$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet_phase = 0;
  bit  long_stall_req = 0;
  bit  long_stall_done = 0;
  int  ready_stall_left = 0;
  int  send_gap = 0;
  bit  took_item = 0;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Follow up to limit links; returns ST_OK when all were followed.
  function automatic status_t follow_links(int start, int limit, output int pos, output int cnt);
    int cur;
    int v;
    cur = start;
    cnt = 0;
    pos = 0;
    while (cnt < limit) begin
      if (cur >= Entries) return ST_RANGE;
      v = link_tab[cur];
      if (v == FreeMark) return ST_FREE;
      if (v == 0) begin
        pos = cur;
        return ST_END;
      end
      if (v >= Entries) return ST_RANGE;
      cur = v;
      cnt++;
    end
    pos = cur;
    return ST_OK;
  endfunction

  function automatic status_t verify_chain(int start, output int last);
    int cnt;
    status_t st;
    last = 0;
    if (start == 0 || start >= Entries) return ST_RANGE;
    st = follow_links(start, Entries, last, cnt);
    if (st == ST_END) return ST_OK;
    if (st == ST_OK) return ST_LOOP;
    return st;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < Entries; i++)
      if (link_tab[i] == FreeMark) return i;
    return -1;
  endfunction

  // Apply one command to the predicted table and return its reply.
  function automatic chain_reply_t predict_chain_op(chain_cmd_t c);
    chain_reply_t r;
    int pos;
    int cnt;
    int fr;
    int cur;
    int nxt;
    status_t st;
    r = '{st: ST_OK, blk: '0, len: '0};
    case (c.act)
      ACT_NEXT: begin
        if (link_tab[c.blk] == FreeMark) r.st = ST_FREE;
        else if (link_tab[c.blk] >= Entries) r.st = ST_RANGE;
        else r.blk = link_tab[c.blk][6:0];
      end
      ACT_NTH: begin
        if (c.steps == 0) r.blk = c.blk;
        else begin
          st = follow_links(c.blk, c.steps, pos, cnt);
          if (st == ST_OK) r.blk = pos[6:0];
          else r.st = st;
        end
      end
      ACT_LENGTH: begin
        st = follow_links(c.blk, Entries, pos, cnt);
        if (st == ST_END) r.len = (cnt > 127) ? 7'd127 : cnt[6:0];
        else r.st = (st == ST_OK) ? ST_LOOP : st;
      end
      ACT_LOOP: r.st = verify_chain(c.blk, pos);
      ACT_NEW: begin
        fr = lowest_free();
        if (fr < 0) r.st = ST_NOSPACE;
        else begin
          link_tab[fr] = '0;
          r.blk = fr[6:0];
        end
      end
      ACT_EXTEND: begin
        r.st = verify_chain(c.blk, pos);
        if (r.st == ST_OK) begin
          fr = lowest_free();
          if (fr < 0) r.st = ST_NOSPACE;
          else begin
            link_tab[pos] = fr[LinkW-1:0];
            link_tab[fr] = '0;
            r.blk = fr[6:0];
          end
        end
      end
      ACT_FREE: begin
        r.st = verify_chain(c.blk, pos);
        if (r.st == ST_OK) begin
          cur = c.blk;
          for (int i = 0; i < Entries; i++) begin
            nxt = link_tab[cur];
            link_tab[cur] = FreeMark;
            if (nxt == 0 || nxt >= Entries) break;
            cur = nxt;
          end
        end
      end
      default: link_tab[c.blk] = '0;
    endcase
    return r;
  endfunction

  task automatic queue_cmd(action_t a, int b, int s);
    chain_cmd_t c;
    c = '{act: a, blk: b[6:0], steps: s[6:0]};
    expected_replies.push_back(predict_chain_op(c));
    pending_cmds.push_back(c);
  endtask

  // Mostly a block in use, so walks get past the first link.
  function automatic int pick_block();
    int r;
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 127);
      for (int i = 0; i < Entries; i++)
        if (link_tab[(r + i) % Entries] != FreeMark) return (r + i) % Entries;
    end
    return $urandom_range(0, 127);
  endfunction

  task automatic queue_random_cmd();
    int w;
    int s;
    action_t a;
    w = $urandom_range(0, 99);
    if (w < 12) a = ACT_NEXT;
    else if (w < 27) a = ACT_NTH;
    else if (w < 39) a = ACT_LENGTH;
    else if (w < 48) a = ACT_LOOP;
    else if (w < 60) a = ACT_NEW;
    else if (w < 80) a = ACT_EXTEND;
    else if (w < 93) a = ACT_FREE;
    else a = ACT_END;
    s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
    queue_cmd(a, pick_block(), s);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at cycle %0d", field, got, want, cycles);
    mismatches++;
  endtask

  // Sender: present items at the falling edge, idling in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !took_item) begin
      in_ch.valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (pending_cmds.size() != 0) begin
      in_ch.valid <= 1'b1;
      in_ch.action <= pending_cmds[0].act;
      in_ch.block <= pending_cmds[0].blk;
      in_ch.step_count <= pending_cmds[0].steps;
      void'(pending_cmds.pop_front());
      if (!quiet_phase && $urandom_range(0, 99) < 15) send_gap <= $urandom_range(1, 19);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk) took_item <= in_ch.valid && in_ch.ready;

  // Receiver: ready bursts plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_stall_req && !long_stall_done) begin
      long_stall_done <= 1'b1;
      ready_stall_left <= 400;
      out_ch.ready <= 1'b0;
    end else if (ready_stall_left > 0) begin
      ready_stall_left <= ready_stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 99) < 8) begin
      ready_stall_left <= $urandom_range(0, 18);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    chain_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected result", out_ch.status, -1);
      end else begin
        want = expected_replies.pop_front();
        if (out_ch.status !== want.st) report_mismatch("status", out_ch.status, want.st);
        if (out_ch.block_out !== want.blk)
          report_mismatch("block_out", out_ch.block_out, want.blk);
        if (out_ch.chain_length !== want.len)
          report_mismatch("chain_length", out_ch.chain_length, want.len);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_NEXT;
    in_ch.block = '0;
    in_ch.step_count = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    for (int i = 0; i < Entries; i++) link_tab[i] = FreeMark;
    link_tab[0] = 8'd1;
    link_tab[1] = 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every action, special cases
    queue_cmd(ACT_NEXT, 0, 0);
    queue_cmd(ACT_NEXT, 1, 0);
    queue_cmd(ACT_NEXT, 127, 127);
    queue_cmd(ACT_NTH, 127, 0);
    queue_cmd(ACT_NTH, 0, 1);
    queue_cmd(ACT_NTH, 0, 5);
    queue_cmd(ACT_NTH, 127, 127);
    queue_cmd(ACT_LENGTH, 0, 0);
    queue_cmd(ACT_LENGTH, 64, 0);
    queue_cmd(ACT_LOOP, 0, 0);
    queue_cmd(ACT_LOOP, 1, 0);
    queue_cmd(ACT_LOOP, 100, 0);
    queue_cmd(ACT_NEW, 0, 0);
    queue_cmd(ACT_EXTEND, 0, 0);
    queue_cmd(ACT_EXTEND, 1, 0);
    queue_cmd(ACT_EXTEND, 90, 0);
    queue_cmd(ACT_LENGTH, 0, 0);
    queue_cmd(ACT_FREE, 0, 0);
    queue_cmd(ACT_FREE, 2, 0);
    queue_cmd(ACT_END, 0, 0);
    queue_cmd(ACT_END, 127, 0);
    queue_cmd(ACT_NEXT, 127, 0);
    wait_drained();

    // Fill the table until new and extend run out of space, with a long receiver stall
    long_stall_req = 1'b1;
    for (int i = 0; i < 130; i++) queue_cmd(ACT_NEW, $urandom_range(0, 127), 0);
    queue_cmd(ACT_EXTEND, 1, 0);
    queue_cmd(ACT_LENGTH, 1, 0);
    wait_drained();
    for (int i = 2; i < Entries; i += 3) queue_cmd(ACT_FREE, i, 0);

    // Random items, with a full drain pause midway and no idling at the end
    for (int i = 0; i < 780; i++) begin
      if (i == 350) wait_drained();
      if (i == 650) begin
        // Let the earlier items go out with idling before the quiet stretch
        while (pending_cmds.size() != 0) @(posedge clk);
        quiet_phase = 1'b1;
      end
      queue_random_cmd();
    end
    wait_drained();
    repeat (600) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ fat_chain_allocator.f @@
rtl/fca_pkg.sv
rtl/fca_if.sv
rtl/fca_table.sv
rtl/fca_seq.sv
rtl/fat_chain_allocator.sv
bench/fat_chain_allocator_tb.sv
